// ===== hdl/rse_pkg.sv =====
// Shared types and constants for the RV32 subset execute block.
package rse_pkg;

  localparam int DM_ADDR_W = 15;

  localparam logic [1:0] OP_EXEC         = 2'd0;
  localparam logic [1:0] OP_PRELOAD_REG  = 2'd1;
  localparam logic [1:0] OP_PRELOAD_DATA = 2'd2;

  localparam logic [6:0] OPC_ADD  = 7'h33;
  localparam logic [6:0] OPC_ADDI = 7'h13;
  localparam logic [6:0] OPC_LW   = 7'h03;
  localparam logic [6:0] OPC_SW   = 7'h23;
  localparam logic [6:0] OPC_BR   = 7'h63;
  localparam logic [6:0] OPC_LUI  = 7'h37;
  localparam logic [6:0] OPC_HALT = 7'h7F;

  localparam logic [2:0] F3_BEQ = 3'd0;
  localparam logic [2:0] F3_BLT = 3'd4;

  localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] instruction;
    logic [9:0]  target_index;
    logic [31:0] load_value;
  } cmd_t;

  typedef struct packed {
    logic [14:0] next_pc;
    logic        halted;
    logic        unknown_opcode;
    logic        reg_write_valid;
    logic [4:0]  reg_write_index;
    logic [31:0] reg_write_value;
    logic        mem_write_valid;
    logic [9:0]  mem_write_addr;
    logic [31:0] mem_write_value;
  } rsp_t;

  typedef struct packed {
    logic       en;
    logic [4:0] addr_a;
    logic [4:0] addr_b;
  } rf_rd_t;

  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] data;
  } rf_wr_t;

  typedef struct packed {
    logic                 rd_en;
    logic                 wr_en;
    logic [DM_ADDR_W-1:0] addr;
    logic [31:0]          wdata;
  } dm_req_t;

endpackage

// ===== hdl/rse_regfile.sv =====
// Register file: 32 x 32 synchronous memory, two read ports, valid bits for reset-to-zero.
module rse_regfile (
  input  logic           clk,
  input  logic           rst,
  input  rse_pkg::rf_rd_t rd,
  input  rse_pkg::rf_wr_t wr,
  output logic [31:0]    data_a,
  output logic [31:0]    data_b
);

  logic [31:0] mem [32];
  logic [31:0] vld;
  logic [31:0] q_a;
  logic [31:0] q_b;
  logic        v_a;
  logic        v_b;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
    if (rd.en) begin
      q_a <= mem[rd.addr_a];
      q_b <= mem[rd.addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      v_a <= 1'b0;
      v_b <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.idx] <= 1'b1;
      end
      if (rd.en) begin
        v_a <= vld[rd.addr_a];
        v_b <= vld[rd.addr_b];
      end
    end
  end

  assign data_a = v_a ? q_a : '0;
  assign data_b = v_b ? q_b : '0;

endmodule

// ===== hdl/rse_dmem.sv =====
// Data memory: single-port synchronous RAM with a registered read.
module rse_dmem #(
  parameter int DATA_WORDS = 1024
) (
  input  logic             clk,
  input  rse_pkg::dm_req_t req,
  output logic [31:0]      rdata
);

  localparam int AW = $clog2(DATA_WORDS);

  logic [31:0] mem [DATA_WORDS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata <= mem[req.addr[AW-1:0]];
    end
  end

endmodule

// ===== hdl/rv32_subset_execute.sv =====
// Top level: three-stage execute pipeline around the register file and data memory.
// Each accepted request is registered in the b stage, then the c stage, then the rsp output.
// Throughput: one request per cycle unless rsp is stalled; forwarding from the writeback
// stage and the previous register write covers back-to-back dependencies, including loads.
// A stalled response freezes all stages and both memories together.
// Reset clears pc, halted, stage valids and register valid bits; data memory is not cleared.
// DATA_WORDS and INST_WORDS must be powers of two; the block does not enforce this.
module rv32_subset_execute #(
  parameter int DATA_WORDS = 1024,
  parameter int INST_WORDS = 32768
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  rse_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rse_pkg::rsp_t rsp
);

  localparam int AW = $clog2(DATA_WORDS);
  localparam int PW = $clog2(INST_WORDS);

  function automatic logic [9:0] imm_div4(input logic [11:0] v);
    imm_div4 = v[11:2] + {9'd0, v[11] & (|v[1:0])};
  endfunction

  function automatic logic [10:0] off_div4(input logic [12:0] v);
    off_div4 = v[12:2] + {10'd0, v[12] & v[1]};
  endfunction

  logic             advance;
  logic             accept;

  logic             b_valid;
  rse_pkg::cmd_t    b_cmd;
  logic             c_valid;
  rse_pkg::rsp_t    c_rsp;
  logic             c_load;
  logic [31:0]      c_value;
  rse_pkg::rsp_t    c_out;

  logic             lw_valid;
  logic [4:0]       lw_idx;
  logic [31:0]      lw_val;

  logic [PW-1:0]    pc;
  logic [PW-1:0]    pc_next;
  logic             stopped;
  logic             stopped_next;

  rse_pkg::rf_rd_t  rf_rd;
  rse_pkg::rf_wr_t  rf_wr;
  rse_pkg::dm_req_t dm_req;
  logic [31:0]      rf_a;
  logic [31:0]      rf_b;
  logic [31:0]      dm_rdata;

  rse_pkg::rsp_t    b_rsp;
  logic             b_load;

  logic [31:0]      ins;
  logic [6:0]       opc;
  logic [4:0]       rd_idx;
  logic [2:0]       f3;
  logic [4:0]       rs1;
  logic [4:0]       rs2;
  logic [31:0]      opa;
  logic [31:0]      opb;
  logic [11:0]      imm;
  logic [9:0]       imm_q;
  logic [31:0]      addr_sum;
  logic [14:0]      tgt15;
  logic [AW-1:0]    addr_aw;
  logic [14:0]      addr15;
  logic [12:0]      br_off;
  logic [10:0]      br_q;
  logic [15:0]      br_q_ext;
  logic [PW-1:0]    pc_inc;
  logic [PW-1:0]    br_tgt;
  logic             take;

  assign advance   = !(rsp_valid && rsp_stall);
  assign cmd_stall = !advance;
  assign accept    = cmd_valid && advance;

  assign rf_rd.en     = advance;
  assign rf_rd.addr_a = cmd.instruction[19:15];
  assign rf_rd.addr_b = cmd.instruction[24:20];

  rse_regfile u_rf (
    .clk    (clk),
    .rst    (rst),
    .rd     (rf_rd),
    .wr     (rf_wr),
    .data_a (rf_a),
    .data_b (rf_b)
  );

  rse_dmem #(
    .DATA_WORDS (DATA_WORDS)
  ) u_dm (
    .clk   (clk),
    .req   (dm_req),
    .rdata (dm_rdata)
  );

  assign c_value = c_load ? dm_rdata : c_rsp.reg_write_value;

  always_comb begin
    c_out                 = c_rsp;
    c_out.reg_write_value = c_value;
  end

  assign rf_wr.en   = advance && c_valid && c_rsp.reg_write_valid;
  assign rf_wr.idx  = c_rsp.reg_write_index;
  assign rf_wr.data = c_value;

  assign ins    = b_cmd.instruction;
  assign opc    = ins[6:0];
  assign rd_idx = ins[11:7];
  assign f3     = ins[14:12];
  assign rs1    = ins[19:15];
  assign rs2    = ins[24:20];

  always_comb begin
    priority if (c_valid && c_rsp.reg_write_valid && c_rsp.reg_write_index == rs1) begin
      opa = c_value;
    end else if (lw_valid && lw_idx == rs1) begin
      opa = lw_val;
    end else begin
      opa = rf_a;
    end
    priority if (c_valid && c_rsp.reg_write_valid && c_rsp.reg_write_index == rs2) begin
      opb = c_value;
    end else if (lw_valid && lw_idx == rs2) begin
      opb = lw_val;
    end else begin
      opb = rf_b;
    end
  end

  assign imm      = (opc == rse_pkg::OPC_SW) ? {ins[31:25], ins[11:7]} : ins[31:20];
  assign imm_q    = imm_div4(imm);
  assign addr_sum = opa + {{22{imm_q[9]}}, imm_q};
  assign tgt15    = 15'(b_cmd.target_index);
  assign br_off   = {ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign br_q     = off_div4(br_off);
  assign br_q_ext = {{5{br_q[10]}}, br_q};
  assign pc_inc   = pc + PW'(1);
  assign br_tgt   = pc + br_q_ext[PW-1:0];

  always_comb begin
    unique case (f3)
      rse_pkg::F3_BEQ: take = (opa == opb);
      rse_pkg::F3_BLT: take = ($signed(opa) < $signed(opb));
      default:         take = 1'b0;
    endcase
  end

  always_comb begin
    b_rsp        = '0;
    b_load       = 1'b0;
    pc_next      = pc;
    stopped_next = stopped;
    addr_aw      = addr_sum[AW-1:0];
    dm_req.rd_en = advance;
    dm_req.wr_en = 1'b0;
    dm_req.wdata = opb;
    if (b_valid) begin
      unique case (b_cmd.operation)
        rse_pkg::OP_EXEC: begin
          if (!stopped) begin
            pc_next = pc_inc;
            unique case (opc)
              rse_pkg::OPC_ADD: begin
                b_rsp.reg_write_valid = (rd_idx != '0);
                b_rsp.reg_write_value = opa + opb;
              end
              rse_pkg::OPC_ADDI: begin
                b_rsp.reg_write_valid = (rd_idx != '0);
                b_rsp.reg_write_value = opa + {{20{ins[31]}}, ins[31:20]};
              end
              rse_pkg::OPC_LW: begin
                b_rsp.reg_write_valid = (rd_idx != '0);
                b_load                = (rd_idx != '0);
              end
              rse_pkg::OPC_SW: begin
                b_rsp.mem_write_valid = 1'b1;
                b_rsp.mem_write_value = opb;
                dm_req.wr_en          = advance;
              end
              rse_pkg::OPC_LUI: begin
                b_rsp.reg_write_valid = (rd_idx != '0);
                b_rsp.reg_write_value = ins & rse_pkg::UPPER_MASK;
              end
              rse_pkg::OPC_BR: begin
                pc_next = take ? br_tgt : pc_inc;
              end
              rse_pkg::OPC_HALT: begin
                pc_next      = pc;
                stopped_next = 1'b1;
              end
              default: begin
                pc_next              = pc;
                stopped_next         = 1'b1;
                b_rsp.unknown_opcode = 1'b1;
              end
            endcase
            if (b_rsp.reg_write_valid) begin
              b_rsp.reg_write_index = rd_idx;
            end else begin
              b_rsp.reg_write_value = '0;
            end
          end
        end
        rse_pkg::OP_PRELOAD_REG: begin
          if (b_cmd.target_index[9:5] == '0 && b_cmd.target_index[4:0] != '0) begin
            b_rsp.reg_write_valid = 1'b1;
            b_rsp.reg_write_index = b_cmd.target_index[4:0];
            b_rsp.reg_write_value = b_cmd.load_value;
          end
        end
        rse_pkg::OP_PRELOAD_DATA: begin
          addr_aw               = tgt15[AW-1:0];
          b_rsp.mem_write_valid = 1'b1;
          b_rsp.mem_write_value = b_cmd.load_value;
          dm_req.wr_en          = advance;
          dm_req.wdata          = b_cmd.load_value;
        end
        default: begin
        end
      endcase
    end
    addr15 = 15'(addr_aw);
    if (b_rsp.mem_write_valid) begin
      b_rsp.mem_write_addr = addr15[9:0];
    end
    b_rsp.next_pc = 15'(pc_next);
    b_rsp.halted  = stopped_next;
  end

  assign dm_req.addr = addr15;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      rsp_valid <= 1'b0;
      lw_valid  <= 1'b0;
      pc        <= '0;
      stopped   <= 1'b0;
    end else if (advance) begin
      b_valid   <= accept;
      c_valid   <= b_valid;
      rsp_valid <= c_valid;
      lw_valid  <= rf_wr.en;
      if (b_valid) begin
        pc      <= pc_next;
        stopped <= stopped_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_cmd  <= cmd;
      c_rsp  <= b_rsp;
      c_load <= b_load;
      lw_idx <= rf_wr.idx;
      lw_val <= rf_wr.data;
      rsp    <= c_out;
    end
  end

  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    rf_wr.en |-> rf_wr.idx != 5'd0)
    else $error("register x0 written");

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("halted state cleared without reset");

  a_stopped_no_store: assert property (@(posedge clk) disable iff (rst)
    (b_valid && stopped && b_cmd.operation == rse_pkg::OP_EXEC) |-> !dm_req.wr_en)
    else $error("store issued by a halted core");

endmodule

// ===== tb/rv32_subset_execute_tb.sv =====
// Testbench for rv32_subset_execute: directed and random requests checked against a local core model.
`timescale 1ns / 100ps

module rv32_subset_execute_tb;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [2:0] F3_BNE = 3'd1;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_REQUESTS = 1830;

  logic clk;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  rse_pkg::cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rse_pkg::rsp_t rsp;

  rv32_subset_execute u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // architectural state of the local core model
  logic [31:0] arch_regs [32];
  logic [31:0] model_words [1024];
  bit          data_known [1024];
  int          written_addrs [$];
  logic [14:0] arch_pc;
  bit          core_stopped;

  rse_pkg::rsp_t retire_q [$];
  rse_pkg::rsp_t expected_rsp;
  int   burst_left;
  int   sent_requests;
  int   checked_responses;
  int   executed_count;
  int   preload_count;
  int   mismatches;
  int   idle_cycles;
  int   stall_mode;
  int   stall_phase_left;
  int   stall_tick;

  function automatic logic [9:0] mem_word(input logic [31:0] base, input logic [11:0] imm12);
    int off;
    off = $signed(imm12);
    return 10'(base + 32'(off / 4));
  endfunction

  function automatic void note_data_write(input logic [9:0] addr, input logic [31:0] value);
    model_words[addr] = value;
    if (!data_known[addr]) begin
      data_known[addr] = 1'b1;
      written_addrs.push_back(int'(addr));
    end
  endfunction

  function automatic rse_pkg::rsp_t retire_model(input rse_pkg::cmd_t c);
    rse_pkg::rsp_t r;
    logic [31:0] ins;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] res;
    logic        wr;
    logic [4:0]  rd;
    logic [9:0]  addr;
    logic [14:0] npc;
    int          boff;
    r = '0;
    ins = c.instruction;
    if (c.operation == rse_pkg::OP_PRELOAD_REG) begin
      preload_count++;
      if (c.target_index < 10'd32 && c.target_index != 10'd0) begin
        arch_regs[c.target_index[4:0]] = c.load_value;
        r.reg_write_valid = 1'b1;
        r.reg_write_index = c.target_index[4:0];
        r.reg_write_value = c.load_value;
      end
    end else if (c.operation == rse_pkg::OP_PRELOAD_DATA) begin
      preload_count++;
      note_data_write(c.target_index, c.load_value);
      r.mem_write_valid = 1'b1;
      r.mem_write_addr = c.target_index;
      r.mem_write_value = c.load_value;
    end else if (c.operation == rse_pkg::OP_EXEC && !core_stopped) begin
      executed_count++;
      rd = ins[11:7];
      a = arch_regs[ins[19:15]];
      b = arch_regs[ins[24:20]];
      res = '0;
      wr = 1'b0;
      npc = arch_pc + 15'd1;
      case (ins[6:0])
        rse_pkg::OPC_ADD: begin
          res = a + b;
          wr = 1'b1;
        end
        rse_pkg::OPC_ADDI: begin
          res = a + {{20{ins[31]}}, ins[31:20]};
          wr = 1'b1;
        end
        rse_pkg::OPC_LW: begin
          res = model_words[mem_word(a, ins[31:20])];
          wr = 1'b1;
        end
        rse_pkg::OPC_SW: begin
          addr = mem_word(a, {ins[31:25], ins[11:7]});
          note_data_write(addr, b);
          r.mem_write_valid = 1'b1;
          r.mem_write_addr = addr;
          r.mem_write_value = b;
        end
        rse_pkg::OPC_LUI: begin
          res = ins & rse_pkg::UPPER_MASK;
          wr = 1'b1;
        end
        rse_pkg::OPC_BR: begin
          boff = $signed({ins[31], ins[7], ins[30:25], ins[11:8], 1'b0});
          if ((ins[14:12] == rse_pkg::F3_BEQ && a == b) ||
              (ins[14:12] == rse_pkg::F3_BLT && $signed(a) < $signed(b)))
            npc = 15'(int'(arch_pc) + boff / 4);
        end
        rse_pkg::OPC_HALT: begin
          core_stopped = 1'b1;
          npc = arch_pc;
        end
        default: begin
          core_stopped = 1'b1;
          r.unknown_opcode = 1'b1;
          npc = arch_pc;
        end
      endcase
      if (wr && rd != 5'd0) begin
        arch_regs[rd] = res;
        r.reg_write_valid = 1'b1;
        r.reg_write_index = rd;
        r.reg_write_value = res;
      end
      arch_pc = npc;
    end
    r.next_pc = arch_pc;
    r.halted = core_stopped;
    return r;
  endfunction

  // --- encoders ---
  function automatic logic [31:0] enc_r(input logic [4:0] rd, input logic [4:0] rs1,
                                        input logic [4:0] rs2);
    return {7'd0, rs2, rs1, 3'd0, rd, rse_pkg::OPC_ADD};
  endfunction

  function automatic logic [31:0] enc_i(input logic [6:0] opc, input logic [4:0] rd,
                                        input logic [4:0] rs1, input logic [11:0] imm);
    return {imm, rs1, 3'd2, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(input logic [4:0] rs1, input logic [4:0] rs2,
                                        input logic [11:0] imm);
    return {imm[11:5], rs2, rs1, 3'd2, imm[4:0], rse_pkg::OPC_SW};
  endfunction

  function automatic logic [31:0] enc_b(input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [4:0] rs2, input logic [12:0] off);
    return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], rse_pkg::OPC_BR};
  endfunction

  function automatic rse_pkg::cmd_t make_exec(input logic [31:0] ins);
    rse_pkg::cmd_t c;
    c.operation = rse_pkg::OP_EXEC;
    c.instruction = ins;
    c.target_index = 10'($urandom());
    c.load_value = $urandom();
    return c;
  endfunction

  function automatic rse_pkg::cmd_t make_preload(input logic [1:0] op, input logic [9:0] tgt,
                                                 input logic [31:0] value);
    rse_pkg::cmd_t c;
    c.operation = op;
    c.instruction = $urandom();
    c.target_index = tgt;
    c.load_value = value;
    return c;
  endfunction

  function automatic logic [6:0] pick_opcode();
    case ($urandom_range(0, 5))
      0: return rse_pkg::OPC_ADD;
      1: return rse_pkg::OPC_ADDI;
      2: return rse_pkg::OPC_LW;
      3: return rse_pkg::OPC_SW;
      4: return rse_pkg::OPC_BR;
      default: return rse_pkg::OPC_LUI;
    endcase
  endfunction

  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 4) == 0) return 5'($urandom());
    return 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // retarget a load so it only reads a data word that has been written
  function automatic rse_pkg::cmd_t steer_load(input rse_pkg::cmd_t c);
    logic [31:0] base;
    logic [9:0]  delta;
    int          q;
    int          r;
    int          imm;
    if (c.operation == rse_pkg::OP_EXEC && !core_stopped &&
        c.instruction[6:0] == rse_pkg::OPC_LW) begin
      base = arch_regs[c.instruction[19:15]];
      if (!data_known[mem_word(base, c.instruction[31:20])]) begin
        delta = 10'(written_addrs[$urandom_range(0, written_addrs.size() - 1)] - base);
        q = int'(delta);
        if (q >= 512) q -= 1024;
        r = $urandom_range(0, 3);
        if (q > 0) imm = 4 * q + r;
        else if (q < 0) imm = (q == -512) ? 4 * q : 4 * q - r;
        else imm = int'($urandom_range(0, 6)) - 3;
        c.instruction[31:20] = 12'(imm);
      end
    end
    return c;
  endfunction

  function automatic rse_pkg::cmd_t random_request();
    rse_pkg::cmd_t c;
    logic [31:0]   ins;
    int            k;
    int            off;
    c = make_exec($urandom());
    c.load_value = pick_value();
    k = $urandom_range(0, 99);
    if (k < 8) begin
      c.operation = rse_pkg::OP_PRELOAD_REG;
      c.target_index = ($urandom_range(0, 3) == 0) ? 10'($urandom()) : 10'($urandom_range(0, 31));
    end else if (k < 16) begin
      c.operation = rse_pkg::OP_PRELOAD_DATA;
    end else if (k < 19) begin
      c.operation = OP_NONE;
    end else if (k < 32) begin
      c.instruction[6:0] = pick_opcode();
    end else begin
      ins = $urandom();
      ins[6:0] = pick_opcode();
      ins[11:7] = pick_reg();
      ins[19:15] = pick_reg();
      ins[24:20] = pick_reg();
      if (ins[6:0] == rse_pkg::OPC_BR) begin
        if ($urandom_range(0, 7) == 0) ins[14:12] = 3'($urandom());
        else ins[14:12] = $urandom_range(0, 1) ? rse_pkg::F3_BLT : rse_pkg::F3_BEQ;
        if ($urandom_range(0, 1)) begin
          off = int'($urandom_range(0, 40)) - 20;
          ins = enc_b(ins[14:12], ins[19:15], ins[24:20], 13'(off * 2));
        end
      end
      c.instruction = ins;
    end
    return steer_load(c);
  endfunction

  // --- request driver: bursts separated by random gaps ---
  task automatic send_request(input rse_pkg::cmd_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3: gap = $urandom_range(8, 20);
        default: gap = $urandom_range(1, 4);
      endcase
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    retire_q.push_back(retire_model(c));
    sent_requests++;
  endtask

  // --- response stall pattern ---
  always @(posedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_phase_left = $urandom_range(16, 200);
    end else begin
      stall_phase_left--;
    end
    stall_tick++;
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      2: rsp_stall <= (stall_tick % 8 < 3);
      default: rsp_stall <= $urandom_range(0, 1);
    endcase
  end

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      checked_responses++;
      if (retire_q.size() == 0) begin
        $error("response with no request outstanding");
        mismatches++;
      end else begin
        expected_rsp = retire_q.pop_front();
        check_field("next_pc", 32'(expected_rsp.next_pc), 32'(rsp.next_pc));
        check_field("halted", 32'(expected_rsp.halted), 32'(rsp.halted));
        check_field("unknown_opcode", 32'(expected_rsp.unknown_opcode),
                    32'(rsp.unknown_opcode));
        check_field("reg_write_valid", 32'(expected_rsp.reg_write_valid),
                    32'(rsp.reg_write_valid));
        check_field("reg_write_index", 32'(expected_rsp.reg_write_index),
                    32'(rsp.reg_write_index));
        check_field("reg_write_value", expected_rsp.reg_write_value, rsp.reg_write_value);
        check_field("mem_write_valid", 32'(expected_rsp.mem_write_valid),
                    32'(rsp.mem_write_valid));
        check_field("mem_write_addr", 32'(expected_rsp.mem_write_addr),
                    32'(rsp.mem_write_addr));
        check_field("mem_write_value", expected_rsp.mem_write_value, rsp.mem_write_value);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    wait (!rst);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // --- tests ---
  task automatic test_preloads();
    send_request(make_preload(rse_pkg::OP_PRELOAD_REG, 10'd0, 32'hDEAD_BEEF));
    send_request(make_preload(rse_pkg::OP_PRELOAD_REG, 10'd31, 32'hFFFF_FFFF));
    send_request(make_preload(rse_pkg::OP_PRELOAD_REG, 10'd1, 32'h8000_0000));
    send_request(make_preload(rse_pkg::OP_PRELOAD_REG, 10'd1023, 32'h1234_5678));
    send_request(make_preload(rse_pkg::OP_PRELOAD_DATA, 10'd0, 32'h0000_0000));
    send_request(make_preload(rse_pkg::OP_PRELOAD_DATA, 10'd1023, 32'hFFFF_FFFF));
    send_request(make_preload(OP_NONE, 10'($urandom()), $urandom()));
  endtask

  task automatic test_alu();
    send_request(make_exec(enc_r(5'd2, 5'd1, 5'd31)));
    send_request(make_exec(enc_i(rse_pkg::OPC_ADDI, 5'd3, 5'd31, 12'h800)));
    send_request(make_exec(enc_i(rse_pkg::OPC_ADDI, 5'd0, 5'd1, 12'h001)));
    send_request(make_exec(enc_i(rse_pkg::OPC_ADDI, 5'd4, 5'd0, 12'h7FF)));
  endtask

  task automatic test_lui();
    send_request(make_exec({20'hFFFFF, 5'd5, rse_pkg::OPC_LUI}));
  endtask

  task automatic test_load_store();
    send_request(make_exec(enc_s(5'd0, 5'd31, 12'h800)));
    send_request(make_exec(enc_i(rse_pkg::OPC_LW, 5'd6, 5'd0, 12'h800)));
    send_request(make_exec(enc_i(rse_pkg::OPC_LW, 5'd7, 5'd0, 12'h003)));
    send_request(make_exec(enc_s(5'd0, 5'd2, 12'hFFD)));
    send_request(make_exec(enc_i(rse_pkg::OPC_LW, 5'd8, 5'd0, 12'hFFF)));
    send_request(make_exec(enc_i(rse_pkg::OPC_LW, 5'd9, 5'd31, 12'h000)));
  endtask

  task automatic test_branches();
    send_request(make_exec(enc_b(rse_pkg::F3_BEQ, 5'd0, 5'd0, 13'h1000)));
    send_request(make_exec(enc_b(rse_pkg::F3_BLT, 5'd1, 5'd0, 13'h0FFE)));
    send_request(make_exec(enc_b(rse_pkg::F3_BLT, 5'd0, 5'd1, 13'h0010)));
    send_request(make_exec(enc_b(rse_pkg::F3_BEQ, 5'd1, 5'd2, 13'h0010)));
    send_request(make_exec(enc_b(F3_BNE, 5'd1, 5'd2, 13'h0010)));
    send_request(make_exec(enc_b(rse_pkg::F3_BLT, 5'd1, 5'd31, 13'h1FFA)));
  endtask

  task automatic test_random_program(input int count);
    rse_pkg::cmd_t c;
    int            done;
    done = 0;
    while (done < count) begin
      c = random_request();
      send_request(c);
      if (c.operation != OP_NONE) done++;
    end
  endtask

  // stop the core with HALT or an unsupported opcode, then confirm it stays stopped
  task automatic test_stop();
    logic [31:0]   ins;
    rse_pkg::cmd_t c;
    ins = $urandom();
    if ($urandom_range(0, 1)) begin
      ins[6:0] = rse_pkg::OPC_HALT;
    end else begin
      do ins[6:0] = 7'($urandom());
      while (ins[6:0] inside {rse_pkg::OPC_ADD, rse_pkg::OPC_ADDI, rse_pkg::OPC_LW,
                              rse_pkg::OPC_SW, rse_pkg::OPC_BR, rse_pkg::OPC_LUI,
                              rse_pkg::OPC_HALT});
    end
    send_request(make_exec(ins));
    repeat (40) begin
      c = make_exec($urandom());
      c.operation = 2'($urandom());
      c.load_value = pick_value();
      send_request(c);
    end
  endtask

  initial begin
    foreach (arch_regs[i]) arch_regs[i] = '0;
    foreach (data_known[i]) data_known[i] = 1'b0;
    arch_pc = '0;
    core_stopped = 1'b0;
    burst_left = 0;
    stall_mode = 0;
    stall_phase_left = 0;
    stall_tick = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_preloads();
    test_alu();
    test_lui();
    test_load_store();
    test_branches();
    test_random_program(RANDOM_REQUESTS);
    test_stop();
    cmd_valid <= 1'b0;

    while (retire_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d instructions executed, %0d preloads", sent_requests,
             executed_count, preload_count);
    $display("Checked %0d responses, %0d field mismatches", checked_responses, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== rv32_subset_execute.f =====
hdl/rse_pkg.sv
hdl/rse_regfile.sv
hdl/rse_dmem.sv
hdl/rv32_subset_execute.sv
tb/rv32_subset_execute_tb.sv
